### src/sfp_pkg.sv
// Shared types and constants of the sensor frame parser.
// Used by sfp_regs, sfp_parser, sfp_emitter and sensor_frame_parser; depends on nothing.

package sfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [6:0] LONG_LEN    = 7'd24;
    localparam logic [6:0] SHORT_LEN   = 7'd16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_VAR   = 2'd2;

    typedef struct packed {
        logic [47:0] long_cmds;
        logic [7:0]  short_cmd;
        logic [23:0] var_cmds;
    } sfp_cfg_t;

    // One write into the payload store.
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } sfp_wr_t;

    // Result request from the parser, valid for the cycle of the accepting edge.
    typedef struct packed {
        logic       single;
        logic       frame;
        logic       status;
        logic [7:0] command;
        logic [6:0] count;
    } sfp_req_t;

    // Emitter status seen by the parser.
    typedef struct packed {
        logic busy;
        logic out_free;
    } sfp_emit_stat_t;

endpackage

### src/sfp_regs.sv
// Configuration registers of the sensor frame parser behind an APB-style port.
// Depends on sfp_pkg.

module sfp_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output sfp_pkg::sfp_cfg_t cfg
);

    logic [47:0] long_reg;
    logic [7:0]  short_reg;
    logic [23:0] var_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg  <= '0;
            short_reg <= '0;
            var_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == sfp_pkg::REG_LONG)
            begin
                long_reg <= pwdata[47:0];
            end
            if (reg_idx == sfp_pkg::REG_SHORT)
            begin
                short_reg <= pwdata[7:0];
            end
            if (reg_idx == sfp_pkg::REG_VAR)
            begin
                var_reg <= pwdata[23:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == sfp_pkg::REG_LONG)
        begin
            prdata = {16'd0, long_reg};
        end
        else if (reg_idx == sfp_pkg::REG_SHORT)
        begin
            prdata = {56'd0, short_reg};
        end
        else if (reg_idx == sfp_pkg::REG_VAR)
        begin
            prdata = {40'd0, var_reg};
        end
    end

    assign cfg.long_cmds = long_reg;
    assign cfg.short_cmd = short_reg;
    assign cfg.var_cmds  = var_reg;

endmodule

### src/sfp_parser.sv
// Framing state machine: sync, command classification, payload store writes.
// Depends on sfp_pkg; drives the write port of the store in sfp_emitter.

module sfp_parser
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfp_pkg::sfp_cfg_t       cfg,
    input  logic                    in_valid,
    input  logic [7:0]              in_byte,
    output logic                    in_ready,
    input  sfp_pkg::sfp_emit_stat_t estat,
    output sfp_pkg::sfp_wr_t        wr,
    output sfp_pkg::sfp_req_t       req
);

    localparam int CW  = $clog2(MAX_PAYLOAD + 1);
    localparam int CW1 = CW + 1;

    typedef enum logic [7:0] {
        PH_SYNC1 = 8'b0000_0001,
        PH_SYNC2 = 8'b0000_0010,
        PH_CMD   = 8'b0000_0100,
        PH_DATA  = 8'b0000_1000,
        PH_CR    = 8'b0001_0000,
        PH_LF    = 8'b0010_0000,
        PH_VLF   = 8'b0100_0000,
        PH_VST   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        CLS_EMPTY = 2'd0,
        CLS_LONG  = 2'd1,
        CLS_SHORT = 2'd2,
        CLS_VAR   = 2'd3
    } cls_t;

    phase_t          phase_reg, phase_next;
    cls_t            cls_reg, cls_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      hold_reg, hold_next;
    logic            accept;
    logic [CW1-1:0]  cnt_inc;
    logic [CW1-1:0]  cnt_inc2;
    logic [CW1-1:0]  class_len;
    cls_t            cls_in;

    // Long class wins over short, short over variable.
    function automatic cls_t classify(input sfp_pkg::sfp_cfg_t c, input logic [7:0] cmd);
        cls_t res;
        logic hit_long;
        logic hit_var;
        hit_long = 1'b0;
        hit_var  = 1'b0;
        for (int k = 0; k < 6; k++)
        begin
            if (c.long_cmds[8*k +: 8] == cmd)
            begin
                hit_long = 1'b1;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (c.var_cmds[8*k +: 8] == cmd)
            begin
                hit_var = 1'b1;
            end
        end
        if (hit_long)
        begin
            res = CLS_LONG;
        end
        else if (c.short_cmd == cmd)
        begin
            res = CLS_SHORT;
        end
        else if (hit_var)
        begin
            res = CLS_VAR;
        end
        else
        begin
            res = CLS_EMPTY;
        end
        return res;
    endfunction

    assign in_ready = (phase_reg != PH_VST) && !estat.busy && estat.out_free;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = CW1'(cnt_reg) + CW1'(1);
    assign cnt_inc2 = CW1'(cnt_reg) + CW1'(2);
    assign cls_in   = classify(cfg, in_byte);

    always_comb
    begin
        unique case (cls_reg)
            CLS_LONG:  class_len = CW1'(sfp_pkg::LONG_LEN);
            CLS_SHORT: class_len = CW1'(sfp_pkg::SHORT_LEN);
            default:   class_len = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cls_next   = cls_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        wr         = '0;
        req        = '0;

        if (phase_reg == PH_VST)
        begin
            // Second byte of a lone CR pair.
            wr.en      = 1'b1;
            wr.addr    = 6'(cnt_inc);
            wr.data    = hold_reg;
            cnt_next   = CW'(cnt_inc2);
            phase_next = PH_DATA;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (in_byte == sfp_pkg::SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (in_byte == sfp_pkg::SYNC_SECOND)
                    begin
                        phase_next = PH_CMD;
                    end
                    else if (in_byte != sfp_pkg::SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = in_byte;
                    cnt_next   = '0;
                    cls_next   = cls_in;
                    phase_next = (cls_in == CLS_EMPTY) ? PH_CR : PH_DATA;
                end
                PH_DATA:
                begin
                    if (cls_reg == CLS_VAR && in_byte == sfp_pkg::CHAR_CR)
                    begin
                        phase_next = PH_VLF;
                    end
                    else if (CW1'(cnt_reg) >= CW1'(MAX_PAYLOAD))
                    begin
                        req.single = 1'b1;
                        req.status = 1'b1;
                    end
                    else
                    begin
                        wr.en    = 1'b1;
                        wr.addr  = 6'(cnt_reg);
                        wr.data  = in_byte;
                        cnt_next = CW'(cnt_inc);
                        if (cls_reg != CLS_VAR && cnt_inc == class_len)
                        begin
                            phase_next = PH_CR;
                        end
                    end
                end
                PH_CR:
                begin
                    if (in_byte == sfp_pkg::CHAR_CR)
                    begin
                        phase_next = PH_LF;
                    end
                    else
                    begin
                        req.single = 1'b1;
                        req.status = 1'b1;
                    end
                end
                PH_LF:
                begin
                    if (in_byte == sfp_pkg::CHAR_LF)
                    begin
                        req.frame = 1'b1;
                    end
                    else
                    begin
                        req.single = 1'b1;
                        req.status = 1'b1;
                    end
                end
                PH_VLF:
                begin
                    if (in_byte == sfp_pkg::CHAR_LF)
                    begin
                        req.frame = 1'b1;
                    end
                    else if (cnt_inc2 > CW1'(MAX_PAYLOAD))
                    begin
                        req.single = 1'b1;
                        req.status = 1'b1;
                    end
                    else
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = 6'(cnt_reg);
                        wr.data    = sfp_pkg::CHAR_CR;
                        hold_next  = in_byte;
                        phase_next = PH_VST;
                    end
                end
                default:
                begin
                    // Corrupt phase code: report an error and clear the phase, command, class and count.
                    req.single = 1'b1;
                    req.status = 1'b1;
                    phase_next = PH_SYNC1;
                    cmd_next   = '0;
                    cls_next   = CLS_EMPTY;
                    cnt_next   = '0;
                end
            endcase

            if (req.single && req.status && phase_reg != PH_VST
                && (phase_reg == PH_DATA || phase_reg == PH_CR
                    || phase_reg == PH_LF || phase_reg == PH_VLF))
            begin
                phase_next = (in_byte == sfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                cnt_next   = '0;
            end

            if (req.frame)
            begin
                phase_next  = PH_SYNC1;
                req.command = cmd_reg;
                req.count   = 7'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    // Empty payload: one item that carries the command only.
                    req.frame  = 1'b0;
                    req.single = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            cls_reg   <= CLS_EMPTY;
            cmd_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

### src/sfp_emitter.sv
// Payload store and frame readout with the output register of the result channel.
// Depends on sfp_pkg; written by sfp_parser.

module sfp_emitter
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfp_pkg::sfp_wr_t        wr,
    input  sfp_pkg::sfp_req_t       req,
    output sfp_pkg::sfp_emit_stat_t estat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_status,
    output logic [7:0]              out_command,
    output logic [6:0]              out_length,
    output logic [5:0]              out_index,
    output logic [7:0]              out_byte,
    output logic                    out_byte_valid,
    output logic                    out_last
);

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    mem [MAX_PAYLOAD];
    logic [7:0]    rd_data_reg;

    logic          run_reg, run_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [7:0]    cmd_reg, cmd_next;

    logic          ov_reg, ov_next;
    logic          st_reg, st_next;
    logic [7:0]    oc_reg, oc_next;
    logic [6:0]    ol_reg, ol_next;
    logic [5:0]    oi_reg, oi_next;
    logic [7:0]    ob_reg, ob_next;
    logic          obv_reg, obv_next;
    logic          olast_reg, olast_next;

    logic          take;
    logic          issue;
    logic [CW-1:0] rd_idx_inc;
    logic [CW-1:0] pend_inc;

    assign take       = ov_reg && out_ready;
    assign issue      = run_reg && !pend_reg && (!ov_reg || take);
    assign rd_idx_inc = rd_idx_reg + CW'(1);
    assign pend_inc   = CW'(pend_idx_reg) + CW'(1);

    assign estat.busy     = run_reg || pend_reg;
    assign estat.out_free = !ov_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        run_next      = run_reg;
        pend_next     = pend_reg;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = pend_idx_reg;
        n_next        = n_reg;
        cmd_next      = cmd_reg;
        ov_next       = ov_reg;
        st_next       = st_reg;
        oc_next       = oc_reg;
        ol_next       = ol_reg;
        oi_next       = oi_reg;
        ob_next       = ob_reg;
        obv_next      = obv_reg;
        olast_next    = olast_reg;

        if (take)
        begin
            ov_next = 1'b0;
        end

        if (req.single)
        begin
            ov_next    = 1'b1;
            st_next    = req.status;
            oc_next    = req.command;
            ol_next    = '0;
            oi_next    = '0;
            ob_next    = '0;
            obv_next   = 1'b0;
            olast_next = 1'b1;
        end

        if (req.frame)
        begin
            run_next    = 1'b1;
            rd_idx_next = '0;
            n_next      = req.count[CW-1:0];
            cmd_next    = req.command;
        end

        if (issue)
        begin
            pend_next     = 1'b1;
            pend_idx_next = rd_idx_reg[AW-1:0];
            rd_idx_next   = rd_idx_inc;
            if (rd_idx_inc == n_reg)
            begin
                run_next = 1'b0;
            end
        end

        // Read data lands while the output register is known to be empty.
        if (pend_reg)
        begin
            pend_next  = 1'b0;
            ov_next    = 1'b1;
            st_next    = 1'b0;
            oc_next    = cmd_reg;
            ol_next    = 7'(n_reg);
            oi_next    = 6'(pend_idx_reg);
            ob_next    = rd_data_reg;
            obv_next   = 1'b1;
            olast_next = (pend_inc == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            run_reg    <= run_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        n_reg        <= n_next;
        cmd_reg      <= cmd_next;
        st_reg       <= st_next;
        oc_reg       <= oc_next;
        ol_reg       <= ol_next;
        oi_reg       <= oi_next;
        ob_reg       <= ob_next;
        obv_reg      <= obv_next;
        olast_reg    <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign out_status     = st_reg;
    assign out_command    = oc_reg;
    assign out_length     = ol_reg;
    assign out_index      = oi_reg;
    assign out_byte       = ob_reg;
    assign out_byte_valid = obv_reg;
    assign out_last       = olast_reg;

endmodule

### src/sensor_frame_parser.sv
// Top level of the sensor frame parser: configuration port, parser and payload emitter.
// Depends on sfp_pkg, sfp_regs, sfp_parser and sfp_emitter.
//
// Received bytes enter on the s_axis channel, one item per byte. The parser looks for
// frames AA 55 <command> <payload> CR LF; the command's payload class comes from the
// three registers on the APB port (long fixed at 0x00, short fixed at 0x08, variable at
// 0x10). A completed frame leaves on the m_axis channel as one item per payload byte,
// tlast on the final one; a frame with no payload gives a single item with byte_valid
// low, and a framing or overflow error gives a single item with status set.
// A byte is accepted when the emitter is idle and the output register is free; a lone
// CR inside a variable payload stalls input while the byte after it is stored, because
// both stored bytes go through the single write port of the payload store. A frame is
// emitted one store read at a time, each read registered and then loaded into the output
// register before the next; no new byte is accepted until the frame's last read is there.
// The output register parts the two sides: while a result waits there, the next byte is
// accepted as soon as m_axis_tready shows that the register is freed in the same cycle.
// When the receiver stalls, the result holds and input stalls behind it.
// Reset clears the parse state and the configuration registers; the payload store needs
// no clearing, since only entries written for the current frame are ever read.

module sensor_frame_parser
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] frame_command, [14:8] frame_length,
                                        // [20:15] byte_index, [28:21] payload_byte, rest 0
    output logic [1:0]  m_axis_tuser,   // [0] status, [1] byte_valid
    output logic        m_axis_tlast
);

    sfp_pkg::sfp_cfg_t       cfg;
    sfp_pkg::sfp_wr_t        wr;
    sfp_pkg::sfp_req_t       req;
    sfp_pkg::sfp_emit_stat_t estat;

    logic       o_status;
    logic [7:0] o_command;
    logic [6:0] o_length;
    logic [5:0] o_index;
    logic [7:0] o_byte;
    logic       o_byte_valid;

    sfp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfp_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_ready (s_axis_tready),
        .estat    (estat),
        .wr       (wr),
        .req      (req)
    );

    sfp_emitter #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_emitter
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .req            (req),
        .estat          (estat),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (o_status),
        .out_command    (o_command),
        .out_length     (o_length),
        .out_index      (o_index),
        .out_byte       (o_byte),
        .out_byte_valid (o_byte_valid),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, o_byte, o_index, o_length, o_command};
    assign m_axis_tuser = {o_byte_valid, o_status};

endmodule
